// ===== rtl/core/wpa_pkg.sv =====
// Shared types, constants and helpers of the window pixel write address generator.
`default_nettype none

package wpa_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int FRAMES      = 2;
  localparam int MAX_RUN     = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W  = 21;
  localparam int COORD_W = 10;
  localparam int LW_W    = 11;
  localparam int COLOR_W = 16;
  localparam int COUNT_W = 7;
  localparam int BITS_W  = 8;
  localparam int SBIT_W  = 3;
  localparam int MODE_W  = 3;
  localparam int REG_W   = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ADDR_W-1:0] FRAME_WORDS = ADDR_W'(MAX_WIDTH * MAX_HEIGHT);

  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BITS   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SETWIN = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RSTWIN = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PLOT   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_FRAME  = 3'd7;

  localparam logic [REG_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [REG_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_W-1:0] REG_FG_COLOR     = 2'd2;
  localparam logic [REG_W-1:0] REG_BG_COLOR     = 2'd3;

  typedef enum logic [1:0] {
    OP_RUN,
    OP_WIN,
    OP_PLOT,
    OP_FRAME
  } wpa_op_e;

  typedef struct packed {
    logic [LW_W-1:0]    line_width;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } wpa_cfg_t;

  typedef struct packed {
    wpa_op_e             op;
    logic [COUNT_W-1:0]  cnt;
    logic                is_write;
    logic                use_bits;
    logic [COLOR_W-1:0]  color;
    logic [BITS_W-1:0]   bits;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  right;
    logic                frame;
  } wpa_cmd_t;

  function automatic logic [ADDR_W-1:0] frame_base(input logic sel);
    return sel ? FRAME_WORDS : '0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpa_if.sv =====
// Channel interfaces: drawing commands, memory accesses and register writes.
`default_nettype none

interface wpa_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [wpa_pkg::MODE_W-1:0]          mode;
  logic [wpa_pkg::COLOR_W-1:0]         pixel;
  logic [wpa_pkg::COUNT_W-1:0]         count;
  logic [wpa_pkg::BITS_W-1:0]          bits;
  logic [wpa_pkg::SBIT_W-1:0]          start_bit;
  logic [wpa_pkg::COORD_W-1:0]         left;
  logic [wpa_pkg::COORD_W-1:0]         top;
  logic [wpa_pkg::COORD_W-1:0]         right;
  logic                                frame;
  logic [wpa_pkg::COORD_W-1:0]         point_x;
  logic [wpa_pkg::COORD_W-1:0]         point_y;

  modport source (output valid, mode, pixel, count, bits, start_bit, left, top, right,
                  frame, point_x, point_y, input ready);
  modport sink (input valid, mode, pixel, count, bits, start_bit, left, top, right,
                frame, point_x, point_y, output ready);
endinterface

interface wpa_res_if;
  logic                          valid;
  logic                          ready;
  logic [wpa_pkg::ADDR_W-1:0]    mem_addr;
  logic                          is_write;
  logic [wpa_pkg::COLOR_W-1:0]   write_data;
  logic                          last;

  modport source (output valid, mem_addr, is_write, write_data, last, input ready);
  modport sink (input valid, mem_addr, is_write, write_data, last, output ready);
endinterface

interface wpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wpa_pkg::REG_W-1:0]        index;
  logic [wpa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wpa_front.sv =====
// Command front end: decodes a beat, clamps its pixel count and queues the work.
`default_nettype none

module wpa_front (
  wpa_cmd_if.sink            cmd_i,
  input  wpa_pkg::wpa_cfg_t  cfg_regs_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output wpa_pkg::wpa_cmd_t  q_data_o
);

  logic                          keep;
  logic [wpa_pkg::SBIT_W:0]      avail;
  logic [wpa_pkg::LW_W-1:0]      lw_m1;

  assign cmd_i.ready = !q_full_i;
  assign q_push_o    = cmd_i.valid && !q_full_i && keep;
  assign avail       = 4'd8 - {1'b0, cmd_i.start_bit};
  assign lw_m1       = cfg_regs_i.line_width - 11'd1;

  always_comb begin
    keep              = 1'b1;
    q_data_o.op       = wpa_pkg::OP_RUN;
    q_data_o.cnt      = 7'd1;
    q_data_o.is_write = 1'b1;
    q_data_o.use_bits = 1'b0;
    q_data_o.color    = cmd_i.pixel;
    q_data_o.bits     = cmd_i.bits << cmd_i.start_bit;
    q_data_o.col      = cmd_i.left;
    q_data_o.row      = cmd_i.top;
    q_data_o.right    = cmd_i.right;
    q_data_o.frame    = cmd_i.frame;
    case (cmd_i.mode)
      wpa_pkg::MODE_WRITE: begin
      end
      wpa_pkg::MODE_READ: begin
        q_data_o.is_write = 1'b0;
        q_data_o.color    = '0;
      end
      wpa_pkg::MODE_REPEAT: begin
        q_data_o.color = cfg_regs_i.fg_color;
        if (32'(cmd_i.count) > wpa_pkg::MAX_RUN) begin
          q_data_o.cnt = wpa_pkg::COUNT_W'(wpa_pkg::MAX_RUN);
        end else begin
          q_data_o.cnt = cmd_i.count;
        end
        keep = (cmd_i.count != '0);
      end
      wpa_pkg::MODE_BITS: begin
        q_data_o.use_bits = 1'b1;
        if (cmd_i.count > {3'b0, avail}) begin
          q_data_o.cnt = {3'b0, avail};
        end else begin
          q_data_o.cnt = cmd_i.count;
        end
        keep = (cmd_i.count != '0);
      end
      wpa_pkg::MODE_SETWIN: begin
        q_data_o.op = wpa_pkg::OP_WIN;
      end
      wpa_pkg::MODE_RSTWIN: begin
        q_data_o.op    = wpa_pkg::OP_WIN;
        q_data_o.col   = '0;
        q_data_o.row   = '0;
        q_data_o.right = lw_m1[wpa_pkg::COORD_W-1:0];
      end
      wpa_pkg::MODE_PLOT: begin
        q_data_o.op    = wpa_pkg::OP_PLOT;
        q_data_o.color = cfg_regs_i.fg_color;
        q_data_o.col   = cmd_i.point_x;
        q_data_o.row   = cmd_i.point_y;
      end
      wpa_pkg::MODE_FRAME: begin
        q_data_o.op = wpa_pkg::OP_FRAME;
        keep        = (32'(cmd_i.frame) < wpa_pkg::FRAMES);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpa_queue.sv =====
// Short command queue between the front end and the access engine.
`default_nettype none

module wpa_queue #(
  parameter int DEPTH = wpa_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wpa_pkg::wpa_cmd_t  data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output wpa_pkg::wpa_cmd_t  data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpa_pkg::wpa_cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    fill_q, fill_d;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpa_back.sv =====
// Access engine: keeps pen, window and running address and emits memory accesses.
`default_nettype none

module wpa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpa_pkg::wpa_cfg_t  cfg_regs_i,
  input  logic               q_valid_i,
  input  wpa_pkg::wpa_cmd_t  q_data_i,
  output logic               q_pop_o,
  wpa_res_if.source          res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                    state_q, state_d;
  wpa_pkg::wpa_cmd_t             cmd_q, cmd_d;
  logic [wpa_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [wpa_pkg::BITS_W-1:0]    bits_q, bits_d;
  logic [wpa_pkg::COORD_W-1:0]   pen_col_q, pen_col_d;
  logic [wpa_pkg::COORD_W-1:0]   pen_row_q, pen_row_d;
  logic [wpa_pkg::COORD_W-1:0]   win_left_q, win_left_d;
  logic [wpa_pkg::COORD_W-1:0]   win_right_q, win_right_d;
  logic                          draw_sel_q, draw_sel_d;
  logic [wpa_pkg::ADDR_W-1:0]    run_addr_q, run_addr_d;
  logic [wpa_pkg::ADDR_W-1:0]    prod_q, prod_d;

  logic                          out_valid_q;
  logic [wpa_pkg::ADDR_W-1:0]    out_addr_q;
  logic                          out_write_q;
  logic [wpa_pkg::COLOR_W-1:0]   out_data_q;
  logic                          out_last_q;

  logic                          out_free;
  logic                          load;
  logic [wpa_pkg::ADDR_W-1:0]    ld_addr;
  logic                          ld_write;
  logic [wpa_pkg::COLOR_W-1:0]   ld_data;
  logic                          ld_last;

  logic [wpa_pkg::COORD_W-1:0]   op_col;
  logic [wpa_pkg::COORD_W-1:0]   op_row;
  logic [wpa_pkg::ADDR_W-1:0]    sum;
  logic [wpa_pkg::COORD_W:0]     next_col;

  assign res_o.valid      = out_valid_q;
  assign res_o.mem_addr   = out_addr_q;
  assign res_o.is_write   = out_write_q;
  assign res_o.write_data = out_data_q;
  assign res_o.last       = out_last_q;

  assign out_free = !out_valid_q || res_o.ready;
  assign op_col   = (cmd_q.op == wpa_pkg::OP_PLOT) ? cmd_q.col : pen_col_q;
  assign op_row   = (cmd_q.op == wpa_pkg::OP_PLOT) ? cmd_q.row : pen_row_q;
  assign sum      = wpa_pkg::frame_base(draw_sel_q) + prod_q + wpa_pkg::ADDR_W'(op_col);
  assign next_col = {1'b0, pen_col_q} + 11'd1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    pen_col_d   = pen_col_q;
    pen_row_d   = pen_row_q;
    win_left_d  = win_left_q;
    win_right_d = win_right_q;
    draw_sel_d  = draw_sel_q;
    run_addr_d  = run_addr_q;
    prod_d      = prod_q;
    q_pop_o     = 1'b0;
    load        = 1'b0;
    ld_addr     = run_addr_q;
    ld_write    = cmd_q.is_write;
    ld_data     = cmd_q.color;
    ld_last     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          case (q_data_i.op)
            wpa_pkg::OP_RUN: begin
              cnt_d   = q_data_i.cnt;
              bits_d  = q_data_i.bits;
              state_d = ST_EMIT;
            end
            wpa_pkg::OP_WIN: begin
              win_left_d  = q_data_i.col;
              win_right_d = q_data_i.right;
              pen_col_d   = q_data_i.col;
              pen_row_d   = q_data_i.row;
              state_d     = ST_MUL;
            end
            wpa_pkg::OP_PLOT: begin
              state_d = ST_MUL;
            end
            wpa_pkg::OP_FRAME: begin
              draw_sel_d = q_data_i.frame;
              run_addr_d = wpa_pkg::frame_base(q_data_i.frame);
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_d  = wpa_pkg::ADDR_W'(op_row) * wpa_pkg::ADDR_W'(cfg_regs_i.line_width);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (cmd_q.op == wpa_pkg::OP_PLOT) begin
          if (out_free) begin
            load     = 1'b1;
            ld_addr  = sum;
            ld_write = 1'b1;
            ld_last  = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          run_addr_d = sum;
          if (cmd_q.op == wpa_pkg::OP_RUN && cnt_q != '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_last = (cnt_q == 7'd1);
          if (cmd_q.use_bits) begin
            ld_data = bits_q[wpa_pkg::BITS_W-1] ? cfg_regs_i.fg_color
                                                : cfg_regs_i.bg_color;
          end
          cnt_d  = cnt_q - 7'd1;
          bits_d = bits_q << 1;
          if (next_col > {1'b0, win_right_q}) begin
            pen_col_d = win_left_q;
            pen_row_d = pen_row_q + 10'd1;
            state_d   = ST_MUL;
          end else begin
            pen_col_d  = next_col[wpa_pkg::COORD_W-1:0];
            run_addr_d = run_addr_q + 21'd1;
            if (cnt_q == 7'd1) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pen_col_q   <= '0;
      pen_row_q   <= '0;
      win_left_q  <= '0;
      win_right_q <= '1;
      draw_sel_q  <= 1'b0;
      run_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pen_col_q   <= pen_col_d;
      pen_row_q   <= pen_row_d;
      win_left_q  <= win_left_d;
      win_right_q <= win_right_d;
      draw_sel_q  <= draw_sel_d;
      run_addr_q  <= run_addr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    bits_q <= bits_d;
    prod_q <= prod_d;
    if (load) begin
      out_addr_q  <= ld_addr;
      out_write_q <= ld_write;
      out_data_q  <= ld_data;
      out_last_q  <= ld_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/window_pixel_write_address_generator_core.sv =====
// Top level of the window pixel write address generator: registers and block wiring.
//
//   channel  direction  beat
//   cmd_i    in         one drawing command (mode and its operands)
//   res_o    out        one frame-memory access (address, write flag, data, last)
//   cfg_i    in         one register write (index, data)
//
// Pixel accesses leave at one per cycle while res_o is ready and no row wrap is under
// way; a command is popped in the idle state before its first access. Each wrap to the
// next row, and each plot or window command, goes through the row multiply and add.
// The two-entry command queue lets commands be accepted while accesses are stalled.
// Reset sets pen, window, frame select and registers at once; no clearing pass.
`default_nettype none

module window_pixel_write_address_generator_core #(
  parameter int QUEUE_DEPTH = wpa_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wpa_cmd_if.sink    cmd_i,
  wpa_res_if.source  res_o,
  wpa_cfg_if.sink    cfg_i
);

  wpa_pkg::wpa_cfg_t  cfg_regs_q;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  wpa_pkg::wpa_cmd_t  q_wdata;
  wpa_pkg::wpa_cmd_t  q_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_regs_q.line_width <= wpa_pkg::LW_W'(wpa_pkg::MAX_WIDTH);
      cfg_regs_q.fg_color   <= '0;
      cfg_regs_q.bg_color   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        wpa_pkg::REG_LINE_WIDTH: begin
          cfg_regs_q.line_width <= cfg_i.data[wpa_pkg::LW_W-1:0];
        end
        wpa_pkg::REG_FG_COLOR: begin
          cfg_regs_q.fg_color <= cfg_i.data;
        end
        wpa_pkg::REG_BG_COLOR: begin
          cfg_regs_q.bg_color <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  wpa_front u_front (
    .cmd_i      (cmd_i),
    .cfg_regs_i (cfg_regs_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  wpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  wpa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_regs_i (cfg_regs_q),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire
